FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DVRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define DVRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hw/rtl/dvrt_pkg.sv
package dvrt_pkg;

    localparam int AddrW = 32;
    localparam int LenW  = 6;
    localparam int CostW = 9;
    localparam int AgeW  = 3;
    localparam int PortW = 4;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DUMP   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [2:0] ST_INSTALLED = 3'd0;
    localparam logic [2:0] ST_REFRESHED = 3'd1;
    localparam logic [2:0] ST_AGED      = 3'd2;
    localparam logic [2:0] ST_KEPT      = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_RESULT    = 3'd5;

    localparam logic [AgeW-1:0] AGE_MAX = 3'd7;

    typedef struct packed {
        logic [AddrW-1:0] addr;
        logic [AddrW-1:0] mask;
        logic [AddrW-1:0] key;
        logic [LenW-1:0]  len;
        logic [CostW-1:0] cost;
        logic [AgeW-1:0]  age;
        logic [PortW-1:0] port;
    } entry_t;

    // run of leading ones from bit 31
    function automatic logic [LenW-1:0] lead_ones(input logic [AddrW-1:0] m);
        logic [LenW-1:0] n;
        n = LenW'(AddrW);
        for (int i = 0; i < AddrW; i++)
        begin
            if (!m[i])
                n = LenW'(AddrW - 1 - i);
        end
        return n;
    endfunction

    function automatic logic [AddrW-1:0] prefix_mask(input logic [LenW-1:0] len);
        return ~({AddrW{1'b1}} >> len);
    endfunction

endpackage

FILE: hw/rtl/distance_vector_route_table.sv
// Distance-vector route table. A word is taken on start while busy is low.
// Busy drops in the cycle that strobes the item's last result on result_valid,
// so the next word can be taken in that cycle. Results appear for one cycle and
// cannot be held off. An update or lookup scans the entry memory once, one entry
// per cycle through its single registered read port: reads are issued for every
// entry, the last read is evaluated, the scan closes, and a final state decides
// and writes back. A dump rescans for each entry it emits (one scan finds each
// successor in prefix order), so each of its words takes a full scan; an empty
// dump gives a single word after one scan. Configuration (stale_limit) is always
// ready and is meant to be written while busy is low.
module distance_vector_route_table #(
    parameter int NUM_ENTRIES = 32,
    parameter int NUM_PORTS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] addr,
    input  logic [31:0] mask,
    input  logic [7:0]  hops,
    input  logic [3:0]  port,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic        found,
    output logic [3:0]  out_port,
    output logic [31:0] out_addr,
    output logic [31:0] out_mask,
    output logic [8:0]  out_cost,
    output logic        last
);

    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CW = $clog2(NUM_ENTRIES + 1);
    localparam int PW = dvrt_pkg::AddrW + dvrt_pkg::LenW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // entry store: one write port, one registered read port
    dvrt_pkg::entry_t mem [NUM_ENTRIES];
    dvrt_pkg::entry_t rd_data_reg;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    dvrt_pkg::entry_t mem_wdata;

    logic [1:0]  state_reg;
    logic [1:0]  op_reg;
    logic [31:0] addr_reg;
    logic [31:0] mask_reg;
    logic [7:0]  hops_reg;
    logic [3:0]  port_reg;
    logic [2:0]  stale_reg;

    logic [CW-1:0]          issue_cnt_reg;
    logic                   ev_vld_reg;
    logic [IW-1:0]          ev_idx_reg;
    logic [NUM_ENTRIES-1:0] valid_reg;
    logic [CW-1:0]          valid_cnt_reg;
    logic [CW-1:0]          sent_cnt_reg;

    logic                   free_found_reg;
    logic [IW-1:0]          free_idx_reg;
    logic                   hit_found_reg;
    logic [IW-1:0]          hit_idx_reg;
    dvrt_pkg::entry_t       hit_ent_reg;
    logic                   best_found_reg;
    dvrt_pkg::entry_t       best_ent_reg;
    logic                   prev_found_reg;
    logic [PW-1:0]          prev_pair_reg;

    // request decode
    logic [dvrt_pkg::LenW-1:0]  q_len;
    logic [31:0]                q_key;
    logic [dvrt_pkg::CostW-1:0] q_cost;
    dvrt_pkg::entry_t           q_ent;

    assign q_len  = dvrt_pkg::lead_ones(mask_reg);
    assign q_key  = addr_reg & dvrt_pkg::prefix_mask(q_len);
    assign q_cost = {1'b0, hops_reg} + 9'd1;
    assign q_ent  = '{addr: addr_reg, mask: mask_reg, key: q_key, len: q_len,
                      cost: q_cost, age: '0, port: port_reg};

    // per-entry evaluation on the word just read
    logic          ev_v;
    logic          upd_match;
    logic          lk_match;
    logic [PW-1:0] ev_pair;
    logic [PW-1:0] best_pair;
    logic          dp_match;

    assign ev_v      = ev_vld_reg && valid_reg[ev_idx_reg];
    assign upd_match = ev_v && (rd_data_reg.len == q_len) && (rd_data_reg.key == q_key);
    assign lk_match  = ev_v
        && ((addr_reg & dvrt_pkg::prefix_mask(rd_data_reg.len)) == rd_data_reg.key)
        && (!best_found_reg || (rd_data_reg.len > best_ent_reg.len));
    assign ev_pair   = {rd_data_reg.key, rd_data_reg.len};
    assign best_pair = {best_ent_reg.key, best_ent_reg.len};
    assign dp_match  = ev_v && (!prev_found_reg || (ev_pair > prev_pair_reg))
        && (!best_found_reg || (ev_pair < best_pair));

    logic scan_end;
    assign scan_end = (issue_cnt_reg == CW'(NUM_ENTRIES)) && !ev_vld_reg;

    // update decision
    logic                       port_bad;
    logic                       replace;
    logic [dvrt_pkg::AgeW-1:0]  age_inc;
    logic [2:0]                 upd_status;

    assign port_bad = ({1'b0, port_reg} >= 5'(NUM_PORTS));
    assign replace  = (q_cost < hit_ent_reg.cost) || (hit_ent_reg.age >= stale_reg);
    assign age_inc  = (hit_ent_reg.age == dvrt_pkg::AGE_MAX) ? dvrt_pkg::AGE_MAX
                                                            : hit_ent_reg.age + 3'd1;

    always_comb
    begin
        mem_we     = 1'b0;
        mem_waddr  = hit_idx_reg;
        mem_wdata  = hit_ent_reg;
        upd_status = dvrt_pkg::ST_KEPT;
        if (state_reg == S_DONE && op_reg == dvrt_pkg::OP_UPDATE)
        begin
            priority if (port_bad)
            begin
                upd_status = dvrt_pkg::ST_KEPT;
            end
            else if (!hit_found_reg)
            begin
                if (free_found_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = free_idx_reg;
                    mem_wdata  = q_ent;
                    upd_status = dvrt_pkg::ST_INSTALLED;
                end
                else
                begin
                    upd_status = dvrt_pkg::ST_FULL;
                end
            end
            else if (replace)
            begin
                mem_we     = 1'b1;
                mem_wdata  = q_ent;
                upd_status = dvrt_pkg::ST_INSTALLED;
            end
            else if (q_cost == hit_ent_reg.cost)
            begin
                mem_we        = 1'b1;
                mem_wdata.age = '0;
                upd_status    = dvrt_pkg::ST_REFRESHED;
            end
            else if (hit_ent_reg.cost > 9'd1)
            begin
                mem_we        = 1'b1;
                mem_wdata.age = age_inc;
                upd_status    = dvrt_pkg::ST_AGED;
            end
            else
            begin
                upd_status = dvrt_pkg::ST_KEPT;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (state_reg == S_SCAN && issue_cnt_reg != CW'(NUM_ENTRIES))
            rd_data_reg <= mem[issue_cnt_reg[IW-1:0]];
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    logic dump_last;
    assign dump_last = ((sent_cnt_reg + CW'(1)) == valid_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            stale_reg      <= 3'd5;
            valid_reg      <= '0;
            valid_cnt_reg  <= '0;
            sent_cnt_reg   <= '0;
            issue_cnt_reg  <= '0;
            ev_vld_reg     <= 1'b0;
            ev_idx_reg     <= '0;
            free_found_reg <= 1'b0;
            hit_found_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            prev_found_reg <= 1'b0;
            result_valid   <= 1'b0;
            op_reg         <= dvrt_pkg::OP_NONE;
        end
        else
        begin
            result_valid <= 1'b0;
            if (cfg_valid && cfg_ready)
                stale_reg <= cfg_data;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start && op != dvrt_pkg::OP_NONE)
                    begin
                        state_reg      <= S_SCAN;
                        op_reg         <= op;
                        addr_reg       <= addr;
                        mask_reg       <= mask;
                        hops_reg       <= hops;
                        port_reg       <= port;
                        issue_cnt_reg  <= '0;
                        ev_vld_reg     <= 1'b0;
                        free_found_reg <= 1'b0;
                        hit_found_reg  <= 1'b0;
                        best_found_reg <= 1'b0;
                        prev_found_reg <= 1'b0;
                        sent_cnt_reg   <= '0;
                    end
                end
                S_SCAN:
                begin
                    // issue one read a cycle, evaluate it the cycle after
                    if (issue_cnt_reg != CW'(NUM_ENTRIES))
                    begin
                        ev_vld_reg    <= 1'b1;
                        ev_idx_reg    <= issue_cnt_reg[IW-1:0];
                        issue_cnt_reg <= issue_cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ev_vld_reg <= 1'b0;
                    end
                    if (ev_vld_reg && !valid_reg[ev_idx_reg] && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= ev_idx_reg;
                    end
                    if (op_reg == dvrt_pkg::OP_UPDATE && upd_match)
                    begin
                        hit_found_reg <= 1'b1;
                        hit_idx_reg   <= ev_idx_reg;
                        hit_ent_reg   <= rd_data_reg;
                    end
                    if ((op_reg == dvrt_pkg::OP_LOOKUP && lk_match)
                        || (op_reg == dvrt_pkg::OP_DUMP && dp_match))
                    begin
                        best_found_reg <= 1'b1;
                        best_ent_reg   <= rd_data_reg;
                    end
                    if (scan_end)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    result_valid <= 1'b1;
                    status       <= dvrt_pkg::ST_RESULT;
                    found        <= 1'b0;
                    out_port     <= '0;
                    out_addr     <= '0;
                    out_mask     <= '0;
                    out_cost     <= '0;
                    last         <= 1'b1;
                    state_reg    <= S_IDLE;
                    if (op_reg == dvrt_pkg::OP_UPDATE)
                    begin
                        status <= upd_status;
                        if (!port_bad && !hit_found_reg && free_found_reg)
                        begin
                            valid_reg[free_idx_reg] <= 1'b1;
                            valid_cnt_reg           <= valid_cnt_reg + CW'(1);
                        end
                    end
                    else if (op_reg == dvrt_pkg::OP_LOOKUP)
                    begin
                        found    <= best_found_reg;
                        out_port <= best_found_reg ? best_ent_reg.port : 4'd0;
                    end
                    else if (best_found_reg)
                    begin
                        // dump: emit successor, rescan unless it was the last
                        found          <= 1'b1;
                        out_port       <= best_ent_reg.port;
                        out_addr       <= best_ent_reg.addr;
                        out_mask       <= best_ent_reg.mask;
                        out_cost       <= best_ent_reg.cost;
                        last           <= dump_last;
                        prev_found_reg <= 1'b1;
                        prev_pair_reg  <= best_pair;
                        sent_cnt_reg   <= sent_cnt_reg + CW'(1);
                        best_found_reg <= 1'b0;
                        issue_cnt_reg  <= '0;
                        if (!dump_last)
                            state_reg <= S_SCAN;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/dvrt_checker.sv
`include "assert_macros.svh"

module dvrt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  op,
    input logic        result_valid,
    input logic [2:0]  status,
    input logic        found,
    input logic        last
);

    `DVRT_ASSERT_NOW(a_last_frees, result_valid && last, !busy)
    `DVRT_ASSERT_NOW(a_status_range, result_valid, status <= dvrt_pkg::ST_RESULT)
    `DVRT_ASSERT_NOW(a_update_single, result_valid && status != dvrt_pkg::ST_RESULT, last && !found)
    `DVRT_ASSERT_NEXT(a_idle_op, start && !busy && op == dvrt_pkg::OP_NONE, !busy && !result_valid)
    `DVRT_ASSERT_NEXT(a_take_busy, start && !busy && op != dvrt_pkg::OP_NONE, busy && !result_valid)

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .op(op),
    .result_valid(result_valid),
    .status(status),
    .found(found),
    .last(last)
);

FILE: tb/distance_vector_route_table_tb.sv
module distance_vector_route_table_tb;

    localparam int N_ROUTES  = 32;
    localparam int N_IFACES  = 16;
    localparam int WDOG_MAX  = 5000;   // longest quiet stretch is one scan plus a long gap
    localparam int QUIET_MIN = 40;     // one scan plus margin before a register write
    localparam int TAIL_WAIT = 200;

    typedef enum { W_ITEM, W_CFG, W_HOLD } word_kind_t;

    // one pending word for the driver: an item, a register write or a hold
    typedef struct {
        word_kind_t  kind;
        logic [1:0]  op;
        logic [31:0] addr;
        logic [31:0] mask;
        logic [7:0]  hops;
        logic [3:0]  port;
        logic [2:0]  cfg;
    } pend_word_t;

    typedef struct {
        logic [2:0]  status;
        logic        found;
        logic [3:0]  port;
        logic [31:0] addr;
        logic [31:0] mask;
        logic [8:0]  cost;
        logic        last;
    } route_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  op = dvrt_pkg::OP_NONE;
    logic [31:0] addr = '0;
    logic [31:0] mask = '0;
    logic [7:0]  hops = '0;
    logic [3:0]  port = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_data = '0;
    logic        result_valid;
    logic [2:0]  status;
    logic        found;
    logic [3:0]  out_port;
    logic [31:0] out_addr;
    logic [31:0] out_mask;
    logic [8:0]  out_cost;
    logic        last;

    distance_vector_route_table dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .op(op), .addr(addr), .mask(mask), .hops(hops), .port(port),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .result_valid(result_valid), .status(status), .found(found),
        .out_port(out_port), .out_addr(out_addr), .out_mask(out_mask),
        .out_cost(out_cost), .last(last)
    );

    always #5 clk = ~clk;

    // shadow route table, updated as each word is taken
    logic        rt_valid [N_ROUTES];
    logic [31:0] rt_addr  [N_ROUTES];
    logic [31:0] rt_mask  [N_ROUTES];
    logic [8:0]  rt_cost  [N_ROUTES];
    logic [2:0]  rt_age   [N_ROUTES];
    logic [3:0]  rt_port  [N_ROUTES];
    logic [2:0]  stale_lim = 3'd5;

    pend_word_t pending_words [$];
    route_res_t expected_routes [$];

    int  mismatch_count = 0;
    int  items_taken = 0;
    int  results_seen = 0;
    int  cfg_writes = 0;
    int  dumps_taken = 0;
    int  full_seen = 0;
    bit  stim_done = 1'b0;

    initial
    begin
        for (int i = 0; i < N_ROUTES; i++)
            rt_valid[i] = 1'b0;
    end

    // prefix length: leading ones from the top bit
    function automatic int prefix_len(input logic [31:0] m);
        int n;
        n = 0;
        while (n < 32 && m[31 - n])
            n++;
        return n;
    endfunction

    function automatic logic [31:0] len_mask(input int len);
        if (len == 0)
            return 32'd0;
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    function automatic logic [2:0] route_update(input logic [31:0] a, input logic [31:0] m,
                                                input logic [7:0] h, input logic [3:0] p);
        int          len;
        logic [31:0] pm;
        logic [8:0]  c;
        int          hit;
        int          spare;
        len   = prefix_len(m);
        pm    = len_mask(len);
        c     = {1'b0, h} + 9'd1;
        hit   = -1;
        spare = -1;
        if (int'(p) >= N_IFACES)
            return dvrt_pkg::ST_KEPT;
        for (int i = 0; i < N_ROUTES; i++)
        begin
            if (!rt_valid[i])
            begin
                if (spare < 0)
                    spare = i;
            end
            else if (prefix_len(rt_mask[i]) == len && (rt_addr[i] & pm) == (a & pm))
                hit = i;
        end
        if (hit < 0)
        begin
            if (spare < 0)
                return dvrt_pkg::ST_FULL;
            rt_valid[spare] = 1'b1;
            hit = spare;
        end
        else if (!(c < rt_cost[hit] || rt_age[hit] >= stale_lim))
        begin
            if (c == rt_cost[hit])
            begin
                rt_age[hit] = 3'd0;
                return dvrt_pkg::ST_REFRESHED;
            end
            if (rt_cost[hit] > 9'd1)
            begin
                if (rt_age[hit] != 3'd7)
                    rt_age[hit] = rt_age[hit] + 3'd1;
                return dvrt_pkg::ST_AGED;
            end
            return dvrt_pkg::ST_KEPT;
        end
        // fresh install or replacement of a stale/dearer entry
        rt_addr[hit] = a;
        rt_mask[hit] = m;
        rt_cost[hit] = c;
        rt_age[hit]  = 3'd0;
        rt_port[hit] = p;
        return dvrt_pkg::ST_INSTALLED;
    endfunction

    task automatic predict_routes(input pend_word_t w);
        route_res_t  r;
        int          best;
        int          best_len;
        int          len;
        logic [31:0] pm;
        bit          sent [N_ROUTES];
        int          total;
        int          pick;
        logic [31:0] pick_key;
        int          pick_len;
        logic [31:0] key;
        r = '{default: '0};
        r.last = 1'b1;
        case (w.op)
            dvrt_pkg::OP_UPDATE:
            begin
                r.status = route_update(w.addr, w.mask, w.hops, w.port);
                if (r.status == dvrt_pkg::ST_FULL)
                    full_seen++;
                expected_routes.push_back(r);
            end
            dvrt_pkg::OP_LOOKUP:
            begin
                best = -1;
                best_len = 0;
                for (int i = 0; i < N_ROUTES; i++)
                begin
                    if (rt_valid[i])
                    begin
                        len = prefix_len(rt_mask[i]);
                        pm  = len_mask(len);
                        if ((w.addr & pm) == (rt_addr[i] & pm) && (best < 0 || len > best_len))
                        begin
                            best = i;
                            best_len = len;
                        end
                    end
                end
                r.status = dvrt_pkg::ST_RESULT;
                if (best >= 0)
                begin
                    r.found = 1'b1;
                    r.port  = rt_port[best];
                end
                expected_routes.push_back(r);
            end
            dvrt_pkg::OP_DUMP:
            begin
                dumps_taken++;
                total = 0;
                for (int i = 0; i < N_ROUTES; i++)
                begin
                    sent[i] = 1'b0;
                    if (rt_valid[i])
                        total++;
                end
                r.status = dvrt_pkg::ST_RESULT;
                if (total == 0)
                    expected_routes.push_back(r);
                // trie preorder: smallest key first, shorter prefix before longer
                for (int k = 0; k < total; k++)
                begin
                    pick = -1;
                    pick_key = '0;
                    pick_len = 0;
                    for (int i = 0; i < N_ROUTES; i++)
                    begin
                        if (rt_valid[i] && !sent[i])
                        begin
                            len = prefix_len(rt_mask[i]);
                            key = rt_addr[i] & len_mask(len);
                            if (pick < 0 || key < pick_key || (key == pick_key && len < pick_len))
                            begin
                                pick = i;
                                pick_key = key;
                                pick_len = len;
                            end
                        end
                    end
                    sent[pick] = 1'b1;
                    r.found = 1'b1;
                    r.port  = rt_port[pick];
                    r.addr  = rt_addr[pick];
                    r.mask  = rt_mask[pick];
                    r.cost  = rt_cost[pick];
                    r.last  = (k == total - 1);
                    expected_routes.push_back(r);
                end
            end
            default: ;   // unused op: no effect, no word out
        endcase
    endtask

    // gap after a taken word: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        if (r < 17)
            return $urandom_range(1, 3);
        if (r < 19)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ---------------- driver ----------------
    int  gap_left = 0;
    int  quiet_cycles = 0;

    always @(posedge clk or negedge rst_n)
    begin : drive
        logic       nx_start;
        logic       nx_cfg;
        pend_word_t w;
        if (!rst_n)
        begin
            start     <= 1'b0;
            cfg_valid <= 1'b0;
            gap_left  = 0;
            quiet_cycles = 0;
        end
        else
        begin
            nx_start = start;
            nx_cfg   = cfg_valid;
            if (start && !busy)
            begin
                w.kind = W_ITEM;
                w.op = op; w.addr = addr; w.mask = mask; w.hops = hops; w.port = port;
                predict_routes(w);
                items_taken++;
                nx_start = 1'b0;
                gap_left = pick_gap();
            end
            if (cfg_valid && cfg_ready)
            begin
                stale_lim = cfg_data;
                cfg_writes++;
                nx_cfg = 1'b0;
            end
            // the block is idle only once results are all in and it has settled
            if (expected_routes.size() == 0 && !busy && !start)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!nx_start && !nx_cfg)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_words.size() != 0)
                begin
                    w = pending_words[0];
                    case (w.kind)
                        W_ITEM:
                        begin
                            void'(pending_words.pop_front());
                            nx_start = 1'b1;
                            op   <= w.op;
                            addr <= w.addr;
                            mask <= w.mask;
                            hops <= w.hops;
                            port <= w.port;
                        end
                        W_CFG:
                            if (quiet_cycles >= QUIET_MIN)
                            begin
                                void'(pending_words.pop_front());
                                nx_cfg = 1'b1;
                                cfg_data <= w.cfg;
                            end
                        default:
                            if (expected_routes.size() == 0)
                                void'(pending_words.pop_front());
                    endcase
                end
            end
            start     <= nx_start;
            cfg_valid <= nx_cfg;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin : watch
        route_res_t e;
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (expected_routes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: status %0d found %0d port %0d",
                             status, found, out_port);
            end
            else
            begin
                e = expected_routes.pop_front();
                if (status !== e.status || found !== e.found || out_port !== e.port ||
                    out_addr !== e.addr || out_mask !== e.mask || out_cost !== e.cost ||
                    last !== e.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch: exp st %0d f %0d p %0d a %h m %h c %0d l %0d",
                                 e.status, e.found, e.port, e.addr, e.mask, e.cost, e.last);
                        $display("          got st %0d f %0d p %0d a %h m %h c %0d l %0d",
                                 status, found, out_port, out_addr, out_mask, out_cost, last);
                    end
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    int idle_run = 0;

    always @(posedge clk)
    begin
        if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid || !rst_n)
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= WDOG_MAX)
        begin
            $display("watchdog: no progress for %0d cycles", WDOG_MAX);
            $display("[distance_vector_route_table] ERROR");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    logic [31:0] addr_pool [6];

    function automatic pend_word_t mk_item(input logic [1:0] o, input logic [31:0] a,
                                           input logic [31:0] m, input logic [7:0] h,
                                           input logic [3:0] p);
        pend_word_t w;
        w = '{kind: W_ITEM, op: o, addr: a, mask: m, hops: h, port: p, cfg: 3'd0};
        return w;
    endfunction

    task automatic add_update(input logic [31:0] a, input logic [31:0] m,
                              input logic [7:0] h, input logic [3:0] p);
        pending_words.push_back(mk_item(dvrt_pkg::OP_UPDATE, a, m, h, p));
    endtask

    task automatic add_op(input logic [1:0] o, input logic [31:0] a);
        pending_words.push_back(mk_item(o, a, 32'($urandom()), 8'($urandom()),
                                        4'($urandom())));
    endtask

    task automatic add_cfg(input logic [2:0] v);
        pend_word_t w;
        w = '{kind: W_CFG, op: dvrt_pkg::OP_NONE, addr: '0, mask: '0, hops: '0, port: '0,
              cfg: v};
        pending_words.push_back(w);
    endtask

    task automatic add_hold();
        pend_word_t w;
        w = '{kind: W_HOLD, op: dvrt_pkg::OP_NONE, addr: '0, mask: '0, hops: '0, port: '0,
              cfg: '0};
        pending_words.push_back(w);
    endtask

    // random words; addresses mostly near a small pool so prefixes collide
    task automatic add_random(input int n);
        int          got;
        int          r;
        int          len;
        logic [31:0] a;
        logic [31:0] m;
        logic [7:0]  h;
        got = 0;
        while (got < n)
        begin
            r = $urandom_range(0, 99);
            a = ($urandom_range(0, 3) == 0) ? $urandom()
                : addr_pool[$urandom_range(0, 5)] ^ ($urandom() >> $urandom_range(8, 31));
            if (r < 55)
            begin
                case ($urandom_range(0, 6))
                    0: len = 0;
                    1: len = 8;
                    2: len = 16;
                    3: len = 24;
                    4: len = 32;
                    default: len = $urandom_range(0, 32);
                endcase
                m = len_mask(len);
                if ($urandom_range(0, 9) == 0)
                    m = $urandom();
                else if ($urandom_range(0, 4) == 0)
                    m = m | ($urandom() & ~len_mask(len + (len < 32)));
                h = ($urandom_range(0, 4) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 6));
                add_update(a, m, h, 4'($urandom()));
                got++;
            end
            else if (r < 82)
            begin
                add_op(dvrt_pkg::OP_LOOKUP, a);
                got++;
            end
            else if (r < 92)
            begin
                add_op(dvrt_pkg::OP_DUMP, a);
                got++;
            end
            else
                add_op(dvrt_pkg::OP_NONE, a);
        end
    endtask

    initial
    begin
        for (int i = 0; i < 6; i++)
            addr_pool[i] = $urandom();

        // directed: empty table, install/keep/refresh/age/replace, odd masks
        add_op(dvrt_pkg::OP_LOOKUP, 32'h0A01_0203);
        add_op(dvrt_pkg::OP_DUMP, 32'h0);
        add_update(32'h0A00_0000, 32'hFF00_0000, 8'd0, 4'd1);
        add_update(32'h0A12_3456, 32'hFF00_0000, 8'd3, 4'd2);   // dearer on cost one: kept
        add_update(32'h0A01_0000, 32'hFFFF_0000, 8'd2, 4'd2);
        add_update(32'h0A01_0000, 32'hFFFF_0000, 8'd2, 4'd3);   // equal cost: refresh
        add_update(32'h0A01_0000, 32'hFFFF_0000, 8'd5, 4'd3);   // dearer: age
        add_update(32'h0A01_FFFF, 32'hFFFF_0000, 8'd1, 4'd4);   // cheaper: replace
        add_update(32'h0000_0000, 32'h0000_0000, 8'd255, 4'd15);
        add_update(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 4'd0);
        add_update(32'hC0A8_0100, 32'hFF00_FF00, 8'd7, 4'd9);   // non-contiguous mask
        add_op(dvrt_pkg::OP_LOOKUP, 32'h0A01_0203);
        add_op(dvrt_pkg::OP_LOOKUP, 32'h0AFF_0000);
        add_op(dvrt_pkg::OP_LOOKUP, 32'h5555_5555);
        add_op(dvrt_pkg::OP_LOOKUP, 32'hFFFF_FFFF);
        add_op(dvrt_pkg::OP_NONE, 32'hFFFF_FFFF);
        add_op(dvrt_pkg::OP_DUMP, 32'h0);
        // age up to the stale limit, then a dearer route takes over
        for (int i = 0; i < 6; i++)
            add_update(32'h0A01_0000, 32'hFFFF_0000, 8'd9, 4'($urandom()));
        add_op(dvrt_pkg::OP_DUMP, 32'h0);

        // stale limit zero: any offer replaces
        add_hold();
        add_cfg(3'd0);
        add_update(32'h0A01_0000, 32'hFFFF_0000, 8'd200, 4'd5);
        add_update(32'h0A01_0000, 32'hFFFF_0000, 8'd250, 4'd6);

        add_cfg(3'd7);
        add_random(45);
        add_hold();
        add_cfg(3'd1);
        add_random(45);
        add_cfg(3'd3);
        add_random(8);
        add_op(dvrt_pkg::OP_DUMP, 32'h0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_words.size() == 0 && !start && !cfg_valid);
        wait (expected_routes.size() == 0);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("covered %0d items (%0d dumps), %0d result words, %0d stale-limit writes",
                 items_taken, dumps_taken, results_seen, cfg_writes);
        $display("table-full updates %0d, mismatches %0d", full_seen, mismatch_count);
        if (mismatch_count == 0 && expected_routes.size() == 0)
            $display("[distance_vector_route_table] OK");
        else
            $display("[distance_vector_route_table] ERROR");
        $finish;
    end

endmodule

FILE: distance_vector_route_table.f
+incdir+hw/rtl
hw/rtl/dvrt_pkg.sv
hw/rtl/distance_vector_route_table.sv
hw/rtl/dvrt_checker.sv
tb/distance_vector_route_table_tb.sv
